// ===== rtl/imm_pkg.sv =====
// Shared types and constants of the integer matrix multiplier.
`default_nettype none
package imm_pkg;

    localparam int CFG_W   = 4;
    localparam int IDX_W   = 3;
    localparam int IN_EL_W = 16;
    localparam int PROD_W  = 35;

    localparam logic [1:0] REG_A_ROWS    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_B_COLS    = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_PRODUCT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_LOAD_A  = 2'd0,
        K_LOAD_B  = 2'd1,
        K_RANGE   = 2'd2,
        K_COMPUTE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MAC  = 2'd1,
        BK_EMIT = 2'd2
    } t_bk_state;

    typedef logic signed [PROD_W-1:0] t_acc;

    typedef struct packed {
        logic [CFG_W-1:0] m;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] p;
    } t_dims;

    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [IN_EL_W-1:0]  value;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        t_acc             value;
        logic             last;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/integer_matrix_multiply.sv =====
// Integer matrix multiplier: loads A and B element by element, streams out A*B.
//
// Input stream (s_axis): tuser is the command (load A, load B, compute), tdata
// carries row, column and a signed element. Every load returns one beat on
// the output stream (m_axis) with status accepted or out of range, tlast set.
// A compute returns a_rows*b_cols product beats in row-major order, tlast on
// the final one. Command 3 is consumed without a result.
// Loads run at one beat per cycle while the output is not stalled. A compute
// does one multiply-accumulate per cycle through the element RAM read ports;
// each product also passes through the read, multiply and emit stages.
// A two-entry queue between the input check and the executing sequencer lets
// input beats be taken while the output stalls; when tready is low the output
// register holds its beat and the sequencer waits before its next emit or load.
// Reset clears the sizes to 1 and empties queue and output; element storage
// is not cleared and holds nothing defined until written. The user must write
// the size registers through the cfg port only while the block is idle; the block does not enforce it.
`default_nettype none
module integer_matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // row_index[2:0], col_index[5:3], element_value[21:6]
    input  wire logic [1:0]  i_s_axis_tuser,  // command[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,  // out_row[2:0], out_col[5:3], product_value[40:6]
    output logic [1:0]       o_m_axis_tuser,  // status[1:0]
    output logic             o_m_axis_tlast
);
    logic [imm_pkg::CFG_W-1:0] r_a_rows, r_inner_dim, r_b_cols;
    imm_pkg::t_dims   w_dims;
    imm_pkg::t_q_head w_head;
    logic             w_pop;
    imm_pkg::t_result w_result;

    function automatic logic [imm_pkg::CFG_W-1:0] eff_size(input logic [imm_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            return imm_pkg::CFG_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return imm_pkg::CFG_W'(MAX_DIM);
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows    <= imm_pkg::CFG_W'(1);
            r_inner_dim <= imm_pkg::CFG_W'(1);
            r_b_cols    <= imm_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                imm_pkg::REG_A_ROWS:    r_a_rows    <= i_cfg_data;
                imm_pkg::REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                imm_pkg::REG_B_COLS:    r_b_cols    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_dims.m = eff_size(r_a_rows);
    assign w_dims.n = eff_size(r_inner_dim);
    assign w_dims.p = eff_size(r_b_cols);

    imm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dims    (w_dims),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_command (i_s_axis_tuser),
        .i_row     (i_s_axis_tdata[2:0]),
        .i_col     (i_s_axis_tdata[5:3]),
        .i_value   (i_s_axis_tdata[21:6]),
        .o_head    (w_head),
        .i_pop     (w_pop)
    );

    imm_back #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (w_dims),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = {7'd0, w_result.value, w_result.col, w_result.row};
    assign o_m_axis_tuser = w_result.status;
    assign o_m_axis_tlast = w_result.last;

    // load acknowledges are single-beat responses
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != imm_pkg::ST_PRODUCT |-> o_m_axis_tlast)
        else $error("load acknowledge without tlast");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != imm_pkg::ST_PRODUCT
        |-> o_m_axis_tdata[40:6] == '0)
        else $error("load acknowledge with nonzero product");

    a_prod_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == imm_pkg::ST_PRODUCT
        |-> ({1'b0, o_m_axis_tdata[2:0]} < w_dims.m) && ({1'b0, o_m_axis_tdata[5:3]} < w_dims.p))
        else $error("product position outside result size");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");
endmodule
`default_nettype wire

// ===== rtl/imm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module imm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire logic [WIDTH-1:0]       i_wr_data,
    input  wire logic [AW-1:0]          i_rd_addr,
    output logic      [WIDTH-1:0]       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/imm_front.sv =====
// Front end: accepts input beats, checks indexes, queues operations for the back end.
`default_nettype none
module imm_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire imm_pkg::t_dims          i_dims,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [1:0]              i_command,
    input  wire logic [imm_pkg::IDX_W-1:0]   i_row,
    input  wire logic [imm_pkg::IDX_W-1:0]   i_col,
    input  wire logic [imm_pkg::IN_EL_W-1:0] i_value,
    output imm_pkg::t_q_head             o_head,
    input  wire logic                    i_pop
);
    imm_pkg::t_op     r_q [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    imm_pkg::t_op     w_op;
    logic             w_keep;
    logic             w_push;
    logic [imm_pkg::CFG_W-1:0] w_row, w_col;

    assign w_row = {1'b0, i_row};
    assign w_col = {1'b0, i_col};

    always_comb begin
        w_op.row   = i_row;
        w_op.col   = i_col;
        w_op.value = i_value;
        w_op.kind  = imm_pkg::K_COMPUTE;
        w_keep     = 1'b1;
        unique case (i_command)
            imm_pkg::CMD_LOAD_A: begin
                w_op.kind = (w_row >= i_dims.m || w_col >= i_dims.n) ?
                            imm_pkg::K_RANGE : imm_pkg::K_LOAD_A;
            end
            imm_pkg::CMD_LOAD_B: begin
                w_op.kind = (w_row >= i_dims.n || w_col >= i_dims.p) ?
                            imm_pkg::K_RANGE : imm_pkg::K_LOAD_B;
            end
            imm_pkg::CMD_COMPUTE: begin
                w_op.kind = imm_pkg::K_COMPUTE;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready && w_keep;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        priority if (w_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_op;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.op    = r_q[r_rp];
endmodule
`default_nettype wire

// ===== rtl/imm_back.sv =====
// Back end: executes queued loads and runs the multiply-accumulate sequencer.
`default_nettype none
module imm_back #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire imm_pkg::t_dims    i_dims,
    input  wire imm_pkg::t_q_head  i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output imm_pkg::t_result       o_result
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    imm_pkg::t_bk_state r_state, n_state;
    logic [imm_pkg::IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic              r_v1, n_v1, r_v2, n_v2;
    logic              r_last1, n_last1, r_last2, n_last2;
    logic              r_done, n_done;
    imm_pkg::t_acc     r_acc, n_acc;
    logic signed [2*ELEM_WIDTH-1:0] r_mul;
    logic              r_out_valid, n_out_valid;
    imm_pkg::t_result  r_out, n_out;

    logic              w_we_a, w_we_b;
    logic [AW-1:0]     w_wr_addr, w_rd_a, w_rd_b;
    logic [ELEM_WIDTH-1:0] w_wr_data, w_a_data, w_b_data;
    logic signed [ELEM_WIDTH-1:0] w_a, w_b;
    logic              w_out_free;
    logic              w_k_end, w_j_end, w_i_end;

    assign w_wr_addr = AW'(32'(i_head.op.row) * MAX_DIM + 32'(i_head.op.col));
    assign w_wr_data = ELEM_WIDTH'(signed'(i_head.op.value));
    assign w_rd_a    = AW'(32'(r_i) * MAX_DIM + 32'(r_k));
    assign w_rd_b    = AW'(32'(r_k) * MAX_DIM + 32'(r_j));

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we_a),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_a),
        .o_rd_data (w_a_data)
    );

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we_b),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_b),
        .o_rd_data (w_b_data)
    );

    assign w_a = signed'(w_a_data);
    assign w_b = signed'(w_b_data);

    assign w_out_free = !r_out_valid || i_ready;
    assign w_k_end    = ({1'b0, r_k} + 4'd1 == i_dims.n);
    assign w_j_end    = ({1'b0, r_j} + 4'd1 == i_dims.p);
    assign w_i_end    = ({1'b0, r_i} + 4'd1 == i_dims.m);

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_v1        = 1'b0;
        n_last1     = 1'b0;
        n_v2        = r_v1;
        n_last2     = r_last1;
        n_done      = r_done;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_we_a      = 1'b0;
        w_we_b      = 1'b0;

        if (r_v2) begin
            n_acc = r_acc + imm_pkg::t_acc'(r_mul);
            if (r_last2) begin
                n_done = 1'b1;
            end
        end

        unique case (r_state)
            imm_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.op.kind == imm_pkg::K_COMPUTE) begin
                        o_pop   = 1'b1;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_acc   = '0;
                        n_done  = 1'b0;
                        n_state = imm_pkg::BK_MAC;
                    end else if (w_out_free) begin
                        o_pop        = 1'b1;
                        w_we_a       = (i_head.op.kind == imm_pkg::K_LOAD_A);
                        w_we_b       = (i_head.op.kind == imm_pkg::K_LOAD_B);
                        n_out_valid  = 1'b1;
                        n_out.status = (i_head.op.kind == imm_pkg::K_RANGE) ?
                                       imm_pkg::ST_RANGE : imm_pkg::ST_OK;
                        n_out.row    = i_head.op.row;
                        n_out.col    = i_head.op.col;
                        n_out.value  = '0;
                        n_out.last   = 1'b1;
                    end
                end
            end
            imm_pkg::BK_MAC: begin
                n_v1    = 1'b1;
                n_last1 = w_k_end;
                if (w_k_end) begin
                    n_k     = '0;
                    n_state = imm_pkg::BK_EMIT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            imm_pkg::BK_EMIT: begin
                if (r_done && w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = imm_pkg::ST_PRODUCT;
                    n_out.row    = r_i;
                    n_out.col    = r_j;
                    n_out.value  = r_acc;
                    n_out.last   = w_i_end && w_j_end;
                    n_acc        = '0;
                    n_done       = 1'b0;
                    if (w_j_end) begin
                        n_j = '0;
                        n_i = r_i + 3'd1;
                    end else begin
                        n_j = r_j + 3'd1;
                    end
                    n_state = (w_i_end && w_j_end) ? imm_pkg::BK_IDLE : imm_pkg::BK_MAC;
                end
            end
            default: begin
                n_state = imm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imm_pkg::BK_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_last1 <= n_last1;
        r_last2 <= n_last2;
        r_acc   <= n_acc;
        r_mul   <= w_a * w_b;
        r_out   <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
endmodule
`default_nettype wire

// ===== verif/integer_matrix_multiply_tb.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the integer matrix multiplier.
module integer_matrix_multiply_tb;

    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam int DIM_MAX        = 8;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int ITEM_TARGET    = 200;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic [imm_pkg::IDX_W-1:0]   row;
        logic [imm_pkg::IDX_W-1:0]   col;
        logic [imm_pkg::IN_EL_W-1:0] value;
    } t_mm_cmd;

    typedef struct packed {
        imm_pkg::t_status           status;
        logic [imm_pkg::IDX_W-1:0]  row;
        logic [imm_pkg::IDX_W-1:0]  col;
        logic [imm_pkg::PROD_W-1:0] value;
        logic                       last;
    } t_mm_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [3:0]  i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // row_index[2:0], col_index[5:3], element_value[21:6]
    logic [1:0]  i_s_axis_tuser = '0;   // command[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // out_row[2:0], out_col[5:3], product_value[40:6]
    logic [1:0]  o_m_axis_tuser;        // status[1:0]
    logic        o_m_axis_tlast;

    t_mm_cmd  cmd_queue[$];
    t_mm_beat pending_results[$];

    logic [imm_pkg::CFG_W-1:0]          dim_reg [3];
    logic signed [imm_pkg::IN_EL_W-1:0] a_mem [DIM_MAX*DIM_MAX];
    logic signed [imm_pkg::IN_EL_W-1:0] b_mem [DIM_MAX*DIM_MAX];

    bit a_wr [DIM_MAX*DIM_MAX];
    bit b_wr [DIM_MAX*DIM_MAX];
    int gen_m = 1;
    int gen_n = 1;
    int gen_p = 1;
    int items_made = 0;

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit hold_off = 1'b0;
    bit holdoff_req = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int fail_count = 0;
    int shown = 0;
    int cycle_count = 0;

    integer_matrix_multiply dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic int clamp_dim(input logic [imm_pkg::CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > DIM_MAX) return DIM_MAX;
        return int'(r);
    endfunction

    function automatic int idle_draw(input bit calm);
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [imm_pkg::IN_EL_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return imm_pkg::IN_EL_W'($urandom);
        endcase
    endfunction

    function automatic logic [imm_pkg::CFG_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return imm_pkg::CFG_W'(DIM_MAX);
            1, 2: return imm_pkg::CFG_W'($urandom_range(4, DIM_MAX));
            default: return imm_pkg::CFG_W'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic predict_results(input t_mm_cmd c);
        int m, n, p, rlim, clim;
        longint acc;
        t_mm_beat b;
        m = clamp_dim(dim_reg[imm_pkg::REG_A_ROWS]);
        n = clamp_dim(dim_reg[imm_pkg::REG_INNER_DIM]);
        p = clamp_dim(dim_reg[imm_pkg::REG_B_COLS]);
        b = '0;
        case (c.cmd)
            imm_pkg::CMD_LOAD_A, imm_pkg::CMD_LOAD_B: begin
                rlim = (c.cmd == imm_pkg::CMD_LOAD_A) ? m : n;
                clim = (c.cmd == imm_pkg::CMD_LOAD_A) ? n : p;
                b.row = c.row;
                b.col = c.col;
                b.last = 1'b1;
                if (c.row >= rlim || c.col >= clim) begin
                    b.status = imm_pkg::ST_RANGE;
                end else begin
                    b.status = imm_pkg::ST_OK;
                    if (c.cmd == imm_pkg::CMD_LOAD_A) a_mem[c.row*DIM_MAX + c.col] = c.value;
                    else b_mem[c.row*DIM_MAX + c.col] = c.value;
                end
                pending_results.push_back(b);
            end
            imm_pkg::CMD_COMPUTE: begin
                for (int i = 0; i < m; i++) begin
                    for (int j = 0; j < p; j++) begin
                        acc = 0;
                        for (int k = 0; k < n; k++)
                            acc += longint'(a_mem[i*DIM_MAX + k]) *
                                   longint'(b_mem[k*DIM_MAX + j]);
                        b.status = imm_pkg::ST_PRODUCT;
                        b.row = imm_pkg::IDX_W'(i);
                        b.col = imm_pkg::IDX_W'(j);
                        b.value = acc[imm_pkg::PROD_W-1:0];
                        b.last = (i == m - 1 && j == p - 1);
                        pending_results.push_back(b);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_mm_cmd seen;
        t_mm_beat got, want;
        in_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_taken = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        if (!i_rst_n) begin
            dim_reg = '{4'd1, 4'd1, 4'd1};
        end else if (i_cfg_we) begin
            dim_reg[i_cfg_addr] = i_cfg_data;
        end
        if (in_taken) begin
            seen.cmd = i_s_axis_tuser;
            seen.row = i_s_axis_tdata[2:0];
            seen.col = i_s_axis_tdata[5:3];
            seen.value = i_s_axis_tdata[21:6];
            predict_results(seen);
        end
        if (out_taken) begin
            got.status = imm_pkg::t_status'(o_m_axis_tuser);
            got.row = o_m_axis_tdata[2:0];
            got.col = o_m_axis_tdata[5:3];
            got.value = o_m_axis_tdata[40:6];
            got.last = o_m_axis_tlast;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (shown < MAX_SHOWN)
                    $display("unexpected beat: st %0d r %0d c %0d v %0d l %0d",
                             got.status, got.row, got.col, $signed(got.value), got.last);
                shown++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (shown < MAX_SHOWN) begin
                        $display("mismatch: want st %0d r %0d c %0d v %0d l %0d",
                                 want.status, want.row, want.col, $signed(want.value),
                                 want.last);
                        $display("          got  st %0d r %0d c %0d v %0d l %0d",
                                 got.status, got.row, got.col, $signed(got.value), got.last);
                    end
                    shown++;
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_cmds
        logic nv;
        t_mm_cmd c;
        nv = i_s_axis_tvalid && !in_taken;
        if (!nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() > 0) begin
                c = cmd_queue.pop_front();
                i_s_axis_tuser <= c.cmd;
                i_s_axis_tdata <= {2'b00, c.value, c.col, c.row};
                nv = 1'b1;
                gap_left = idle_draw(send_calm);
            end
        end
        i_s_axis_tvalid <= nv;
    end

    always @(negedge i_clk) begin : drive_ready
        if (out_taken) stall_left = idle_draw(recv_calm);
        else if (stall_left > 0) stall_left--;
        i_m_axis_tready <= (stall_left == 0) && !hold_off;
    end

    // long output stall while loads keep coming, to back up the input
    initial begin : holdoff
        wait (holdoff_req);
        repeat (20) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] cmd, input int row, input int col,
                            input logic [imm_pkg::IN_EL_W-1:0] value);
        t_mm_cmd c;
        c.cmd = cmd;
        c.row = imm_pkg::IDX_W'(row);
        c.col = imm_pkg::IDX_W'(col);
        c.value = value;
        if (cmd == imm_pkg::CMD_LOAD_A && row < gen_m && col < gen_n)
            a_wr[row*DIM_MAX + col] = 1'b1;
        if (cmd == imm_pkg::CMD_LOAD_B && row < gen_n && col < gen_p)
            b_wr[row*DIM_MAX + col] = 1'b1;
        if (cmd != CMD_IGNORED) items_made++;
        cmd_queue.push_back(c);
    endtask

    task automatic push_noise();
        logic [1:0] cmd;
        case ($urandom_range(0, 2))
            0: cmd = imm_pkg::CMD_LOAD_A;
            1: cmd = imm_pkg::CMD_LOAD_B;
            default: cmd = CMD_IGNORED;
        endcase
        push_cmd(cmd, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || i_s_axis_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [imm_pkg::CFG_W-1:0] m,
                            input logic [imm_pkg::CFG_W-1:0] n,
                            input logic [imm_pkg::CFG_W-1:0] p);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= imm_pkg::REG_A_ROWS;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_addr <= imm_pkg::REG_INNER_DIM;
        i_cfg_data <= n;
        @(negedge i_clk);
        i_cfg_addr <= imm_pkg::REG_B_COLS;
        i_cfg_data <= p;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gen_m = clamp_dim(m);
        gen_n = clamp_dim(n);
        gen_p = clamp_dim(p);
    endtask

    task automatic run_phase(input logic [imm_pkg::CFG_W-1:0] m_raw,
                             input logic [imm_pkg::CFG_W-1:0] n_raw,
                             input logic [imm_pkg::CFG_W-1:0] p_raw, input bit squeeze);
        int rounds;
        bit ready;
        set_dims(m_raw, n_raw, p_raw);
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
        if (squeeze) begin
            send_calm = 1'b1;
            holdoff_req = 1'b1;
        end
        rounds = (gen_m*gen_n + gen_n*gen_p > 32) ? 1 : $urandom_range(1, 3);
        repeat (rounds) begin
            if ($urandom_range(0, 4) != 0) begin
                for (int i = 0; i < gen_m; i++) begin
                    for (int k = 0; k < gen_n; k++) begin
                        if (!a_wr[i*DIM_MAX + k] || $urandom_range(0, 2) == 0)
                            push_cmd(imm_pkg::CMD_LOAD_A, i, k, rand_elem());
                        if ($urandom_range(0, 9) == 0) push_noise();
                    end
                end
                for (int k = 0; k < gen_n; k++) begin
                    for (int j = 0; j < gen_p; j++) begin
                        if (!b_wr[k*DIM_MAX + j] || $urandom_range(0, 2) == 0)
                            push_cmd(imm_pkg::CMD_LOAD_B, k, j, rand_elem());
                        if ($urandom_range(0, 9) == 0) push_noise();
                    end
                end
                push_cmd(imm_pkg::CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                         rand_elem());
            end else begin
                repeat ($urandom_range(3, 12)) push_noise();
                ready = 1'b1;
                for (int i = 0; i < gen_m; i++)
                    for (int k = 0; k < gen_n; k++)
                        ready &= a_wr[i*DIM_MAX + k];
                for (int k = 0; k < gen_n; k++)
                    for (int j = 0; j < gen_p; j++)
                        ready &= b_wr[k*DIM_MAX + j];
                if (ready) push_cmd(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000);
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_cmd(imm_pkg::CMD_LOAD_A, 0, 0, 16'h7fff);
        push_cmd(imm_pkg::CMD_LOAD_B, 0, 0, 16'h7fff);
        push_cmd(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000);
        push_cmd(imm_pkg::CMD_LOAD_A, 0, 0, 16'h8000);
        push_cmd(imm_pkg::CMD_LOAD_B, 0, 0, 16'h8000);
        push_cmd(imm_pkg::CMD_COMPUTE, 7, 7, 16'hffff);
        push_cmd(imm_pkg::CMD_LOAD_B, 0, 0, 16'h7fff);
        push_cmd(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000);
        // out-of-range loads are answered with range status and not stored
        push_cmd(imm_pkg::CMD_LOAD_A, 7, 7, 16'hffff);
        push_cmd(imm_pkg::CMD_LOAD_A, 1, 0, 16'h1234);
        push_cmd(imm_pkg::CMD_LOAD_B, 0, 1, 16'h8000);
        push_cmd(imm_pkg::CMD_LOAD_B, 7, 0, 16'h7fff);
        push_cmd(CMD_IGNORED, 7, 7, 16'hffff);
        push_cmd(CMD_IGNORED, 0, 0, 16'h0000);
        push_cmd(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000);
        // grow the sizes; earlier elements stay in place
        set_dims(4'd2, 4'd1, 4'd2);
        push_cmd(imm_pkg::CMD_LOAD_A, 1, 0, 16'hffff);
        push_cmd(imm_pkg::CMD_LOAD_B, 0, 1, 16'h0001);
        push_cmd(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000);

        run_phase(4'd8, 4'd8, 4'd8, 1'b1);
        run_phase(4'd0, 4'd15, 4'd0, 1'b0);
        run_phase(4'd15, 4'd1, 4'd15, 1'b0);
        while (items_made < ITEM_TARGET)
            run_phase(rand_dim(), rand_dim(), rand_dim(), 1'b0);

        wait_idle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/imm_pkg.sv
rtl/imm_ram.sv
rtl/imm_front.sv
rtl/imm_back.sv
rtl/integer_matrix_multiply.sv
verif/integer_matrix_multiply_tb.sv
